// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the top level of the sample conversion block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define CSAT_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed in %m");
// condition must never be seen at a rising clock edge outside reset
`define CSAT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen in %m");
`else
`define CSAT_ASSERT(name, clk, rst, prop)
`define CSAT_NEVER(name, clk, rst, cond)
`endif
`endif

// ===== hw/rtl/csat_pkg.sv =====
// constants, tables, stage types and helpers of the sample conversion block
`timescale 1ns / 1ps
`default_nettype none
package csat_pkg;

   // field widths
   localparam int CodeW      = 16;
   localparam int CentiW     = 15;
   localparam int TcodeW     = 8;
   localparam int VcodeW     = 8;

   // breakpoint table geometry
   localparam int NumPts     = 33;
   localparam int NumSegs    = NumPts - 1;
   localparam int PtIdxW     = $clog2(NumPts);
   localparam int SegIdxW    = $clog2(NumSegs);
   localparam int SpanW      = 10;   // offset into a segment, at most 700
   localparam int StepW      = 3;    // segment width in units of 100
   localparam int HalfBaseW  = 10;   // segment start in half degrees

   // reciprocal division
   localparam int RecipShift   = 20;
   localparam int RecipCentiW  = 20;
   localparam int RecipHalfW   = 17;
   localparam int NumCentiW    = 13;
   localparam int NumHalfW     = 10;
   localparam int FracCentiW   = 9;
   localparam int FracHalfW    = 4;

   // voltage code
   localparam logic [CodeW-1:0] VoltLow  = 16'd20000;
   localparam logic [CodeW-1:0] VoltHigh = 16'd45500;
   localparam logic [CodeW-1:0] VoltBias = 16'd19950;
   localparam int VoltOfsW  = 15;
   localparam int VoltRecipW = 16;
   localparam logic [VoltRecipW-1:0] VoltRecip = 16'd41944;
   localparam int VoltShift = 22;

   // temperature limits in 0.01 C
   localparam logic signed [CentiW-1:0] OutCenti  = -15'sd10000;
   localparam logic signed [CentiW-1:0] MinCenti  = -15'sd4000;
   localparam logic signed [CentiW-1:0] MaxCenti  = 15'sd12000;
   localparam logic signed [CentiW-1:0] ColdCenti = -15'sd2000;
   localparam logic signed [CentiW-1:0] HotCenti  = 15'sd10750;
   localparam logic [TcodeW-1:0] TcodeMax = 8'd255;

   // thermistor breakpoints, descending, 100 uV units, -40 C first, 5 C apart
   localparam logic [CodeW-1:0] PointVolt [NumPts] = '{
      16'd24400, 16'd24200, 16'd24000, 16'd23800, 16'd23500, 16'd23200,
      16'd22700, 16'd22300, 16'd21700, 16'd21100, 16'd20500, 16'd19900,
      16'd19200, 16'd18600, 16'd18000, 16'd17400, 16'd16800, 16'd16300,
      16'd15900, 16'd15500, 16'd15100, 16'd14800, 16'd14500, 16'd14300,
      16'd14000, 16'd13800, 16'd13700, 16'd13500, 16'd13400, 16'd13300,
      16'd13200, 16'd13100, 16'd13000
   };

   // segment widths in units of 100 (10 mV)
   localparam logic [StepW-1:0] SegStep [NumSegs] = '{
      3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd5, 3'd4, 3'd6,
      3'd6, 3'd6, 3'd6, 3'd7, 3'd6, 3'd6, 3'd6, 3'd6,
      3'd5, 3'd4, 3'd4, 3'd4, 3'd3, 3'd3, 3'd2, 3'd3,
      3'd2, 3'd1, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1
   };

   // locate stage result
   typedef struct packed {
      logic [SegIdxW-1:0]  seg;
      logic                in_range;
      logic [SpanW-1:0]    span;
      logic [StepW-1:0]    step;
      logic [VoltOfsW-1:0] volt_ofs;
   } locate_type;

   // divide stage result
   typedef struct packed {
      logic [SegIdxW-1:0]    seg;
      logic                  in_range;
      logic [FracCentiW-1:0] frac_centi;
      logic [FracHalfW-1:0]  frac_half;
      logic [VcodeW-1:0]     volt_code;
   } quot_type;

   // final result beat
   typedef struct packed {
      logic signed [CentiW-1:0] temp_centi;
      logic                     in_range;
      logic [TcodeW-1:0]        temp_code;
      logic [VcodeW-1:0]        volt_code;
   } result_type;

   // ceil(2^20 / (2 * step)): rounds 5 * span / step to 0.01 C
   function automatic logic [RecipCentiW-1:0] recip_centi(input logic [StepW-1:0] step);
      unique case (step)
         3'd1:    recip_centi = 20'd524288;
         3'd2:    recip_centi = 20'd262144;
         3'd3:    recip_centi = 20'd174763;
         3'd4:    recip_centi = 20'd131072;
         3'd5:    recip_centi = 20'd104858;
         3'd6:    recip_centi = 20'd87382;
         3'd7:    recip_centi = 20'd74899;
         default: recip_centi = '0;
      endcase
   endfunction

   // ceil(2^20 / (10 * step)): rounds span / (10 * step) to half degrees
   function automatic logic [RecipHalfW-1:0] recip_half(input logic [StepW-1:0] step);
      unique case (step)
         3'd1:    recip_half = 17'd104858;
         3'd2:    recip_half = 17'd52429;
         3'd3:    recip_half = 17'd34953;
         3'd4:    recip_half = 17'd26215;
         3'd5:    recip_half = 17'd20972;
         3'd6:    recip_half = 17'd17477;
         3'd7:    recip_half = 17'd14980;
         default: recip_half = '0;
      endcase
   endfunction

   // segment start temperature in 0.01 C
   function automatic logic signed [CentiW-1:0] seg_base_centi(input logic [SegIdxW-1:0] seg);
      seg_base_centi = $signed(CentiW'(seg) * 15'd500) - 15'sd4000;
   endfunction

   // segment start temperature as half degrees above -20 C
   function automatic logic signed [HalfBaseW-1:0] seg_base_half(input logic [SegIdxW-1:0] seg);
      seg_base_half = $signed(HalfBaseW'(seg) * 10'd10) - 10'sd40;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/csat_if.sv =====
// request and response channel interfaces of the sample conversion block
`timescale 1ns / 1ps
`default_nettype none
interface csat_req_if;
   import csat_pkg::*;
   logic             valid;
   logic             ready;
   logic [CodeW-1:0] cell_code;

   modport source (output valid, output cell_code, input ready);
   modport sink (input valid, input cell_code, output ready);
endinterface

interface csat_rsp_if;
   import csat_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [CentiW-1:0] temp_centi;
   logic                     in_range;
   logic [TcodeW-1:0]        temp_code;
   logic [VcodeW-1:0]        volt_code;

   modport source (output valid, output temp_centi, output in_range,
                   output temp_code, output volt_code, input ready);
   modport sink (input valid, input temp_centi, input in_range,
                 input temp_code, input volt_code, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/csat_locate.sv =====
// input register and segment search with the segment offset and voltage offset
`timescale 1ns / 1ps
`default_nettype none
module csat_locate (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [csat_pkg::CodeW-1:0] in_code,
   output logic                       out_valid,
   input  logic                       out_ready,
   output csat_pkg::locate_type       out_data
);
   import csat_pkg::*;

   logic             code_vld_ff;
   logic [CodeW-1:0] code_ff;
   logic             loc_vld_ff;
   locate_type       loc_ff;
   locate_type       loc_in;
   logic             code_ready;
   logic             loc_ready;

   logic [NumSegs-1:0] hit;
   logic [SegIdxW-1:0] seg;
   logic [CodeW-1:0]   seg_top;
   logic [CodeW-1:0]   span_full;
   logic [CodeW-1:0]   volt_clamp;
   logic [CodeW-1:0]   volt_diff;

   // stage handshake, bubbles collapse
   assign loc_ready  = !loc_vld_ff || out_ready;
   assign code_ready = !code_vld_ff || loc_ready;
   assign in_ready   = code_ready;
   assign out_valid  = loc_vld_ff;
   assign out_data   = loc_ff;

   // interval compares against every breakpoint pair
   always_comb begin
      for (int i = 0; i < NumSegs; i++) begin
         hit[i] = (code_ff <= PointVolt[i]) && (code_ff >= PointVolt[i+1]);
      end
   end

   // first interval that holds the sample wins
   always_comb begin
      seg = '0;
      for (int i = NumSegs - 1; i >= 0; i--) begin
         if (hit[i]) begin
            seg = SegIdxW'(i);
         end
      end
   end

   // offset from the segment top, voltage clamp and offset
   always_comb begin
      seg_top   = PointVolt[PtIdxW'(seg)];
      span_full = seg_top - code_ff;
      priority if (code_ff < VoltLow) begin
         volt_clamp = VoltLow;
      end else if (code_ff > VoltHigh) begin
         volt_clamp = VoltHigh;
      end else begin
         volt_clamp = code_ff;
      end
      volt_diff         = volt_clamp - VoltBias;
      loc_in.seg        = seg;
      loc_in.in_range   = |hit;
      loc_in.span       = span_full[SpanW-1:0];
      loc_in.step       = SegStep[seg];
      loc_in.volt_ofs   = volt_diff[VoltOfsW-1:0];
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         code_vld_ff <= 1'b0;
         loc_vld_ff  <= 1'b0;
      end else begin
         if (code_ready) begin
            code_vld_ff <= in_valid;
         end
         if (loc_ready) begin
            loc_vld_ff <= code_vld_ff;
         end
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (code_ready && in_valid) begin
         code_ff <= in_code;
      end
      if (loc_ready && code_vld_ff) begin
         loc_ff <= loc_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/csat_divide.sv =====
// reciprocal multiplies for the segment fraction and the voltage code
`timescale 1ns / 1ps
`default_nettype none
module csat_divide (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  csat_pkg::locate_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output csat_pkg::quot_type   out_data
);
   import csat_pkg::*;

   localparam int ProdCentiW = NumCentiW + RecipCentiW;
   localparam int ProdHalfW  = NumHalfW + RecipHalfW;
   localparam int ProdVoltW  = VoltOfsW + VoltRecipW;

   logic                  quot_vld_ff;
   quot_type              quot_ff;
   quot_type              quot_in;
   logic                  quot_ready;
   logic [NumCentiW-1:0]  num_centi;
   logic [NumHalfW-1:0]   num_half;
   logic [ProdCentiW-1:0] prod_centi;
   logic [ProdHalfW-1:0]  prod_half;
   logic [ProdVoltW-1:0]  prod_volt;

   assign quot_ready = !quot_vld_ff || out_ready;
   assign in_ready   = quot_ready;
   assign out_valid  = quot_vld_ff;
   assign out_data   = quot_ff;

   // (10n + k) / 2k gives 0.01 C, (n + 5k) / 10k gives half degrees
   always_comb begin
      num_centi  = NumCentiW'(in_data.span) * 13'd10 + NumCentiW'(in_data.step);
      num_half   = NumHalfW'(in_data.span) + NumHalfW'(in_data.step) * 10'd5;
      prod_centi = ProdCentiW'(num_centi) * ProdCentiW'(recip_centi(in_data.step));
      prod_half  = ProdHalfW'(num_half) * ProdHalfW'(recip_half(in_data.step));
      prod_volt  = ProdVoltW'(in_data.volt_ofs) * ProdVoltW'(VoltRecip);
      quot_in.seg        = in_data.seg;
      quot_in.in_range   = in_data.in_range;
      quot_in.frac_centi = prod_centi[RecipShift +: FracCentiW];
      quot_in.frac_half  = prod_half[RecipShift +: FracHalfW];
      quot_in.volt_code  = prod_volt[VoltShift +: VcodeW];
   end

   // stage valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         quot_vld_ff <= 1'b0;
      end else if (quot_ready) begin
         quot_vld_ff <= in_valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (quot_ready && in_valid) begin
         quot_ff <= quot_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/csat_pack.sv =====
// segment base add, clamping and the output register
`timescale 1ns / 1ps
`default_nettype none
module csat_pack (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  csat_pkg::quot_type   in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output csat_pkg::result_type out_data
);
   import csat_pkg::*;

   logic                        res_vld_ff;
   result_type                  res_ff;
   result_type                  res_in;
   logic                        res_ready;
   logic signed [CentiW-1:0]    centi_sum;
   logic signed [HalfBaseW-1:0] half_sum;

   assign res_ready = !res_vld_ff || out_ready;
   assign in_ready  = res_ready;
   assign out_valid = res_vld_ff;
   assign out_data  = res_ff;

   // segment base plus rounded fraction, code clamp
   always_comb begin
      centi_sum = seg_base_centi(in_data.seg)
                + $signed(CentiW'(in_data.frac_centi));
      half_sum  = seg_base_half(in_data.seg)
                + $signed(HalfBaseW'(in_data.frac_half));
      res_in.in_range   = in_data.in_range;
      res_in.volt_code  = in_data.volt_code;
      res_in.temp_centi = in_data.in_range ? centi_sum : OutCenti;
      priority if (!in_data.in_range || half_sum < 10'sd0) begin
         res_in.temp_code = '0;
      end else if (half_sum > $signed(HalfBaseW'(TcodeMax))) begin
         res_in.temp_code = TcodeMax;
      end else begin
         res_in.temp_code = half_sum[TcodeW-1:0];
      end
   end

   // output valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         res_vld_ff <= 1'b0;
      end else if (res_ready) begin
         res_vld_ff <= in_valid;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (res_ready && in_valid) begin
         res_ff <= res_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/cell_sample_to_temp_and_codes_core.sv =====
// top level of the cell sample to temperature and code converter
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Converts one 16-bit cell sample (100 uV per unit) per beat into an
// interpolated thermistor temperature in 0.01 C, an in-range flag, an 8-bit
// temperature code (0.5 C steps from -20 C) and an 8-bit voltage code (10 mV
// steps from 2.00 V). Throughput is one sample per clock while responses are
// taken. A sample passes four register stages: the input register, the segment
// search register, the register after the reciprocal multipliers and the
// output register. Every stage takes a new beat when it is empty or its
// successor moves, so a held response stalls the pipe only once all stages are
// full. There are no configuration registers and no state beyond the pipeline.
module cell_sample_to_temp_and_codes_core (
   input  logic        clock,
   input  logic        reset,
   csat_req_if.sink    req_chan,
   csat_rsp_if.source  rsp_chan
);
   import csat_pkg::*;

   logic       loc_valid;
   logic       loc_ready;
   locate_type loc_data;
   logic       quot_valid;
   logic       quot_ready;
   quot_type   quot_data;
   result_type res_data;

   // segment search
   csat_locate u_locate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_code   (req_chan.cell_code),
      .out_valid (loc_valid),
      .out_ready (loc_ready),
      .out_data  (loc_data)
   );

   // fraction and voltage code
   csat_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (loc_valid),
      .in_ready  (loc_ready),
      .in_data   (loc_data),
      .out_valid (quot_valid),
      .out_ready (quot_ready),
      .out_data  (quot_data)
   );

   // final assembly and output register
   csat_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (quot_valid),
      .in_ready  (quot_ready),
      .in_data   (quot_data),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (res_data)
   );

   // response beat fields
   assign rsp_chan.temp_centi = res_data.temp_centi;
   assign rsp_chan.in_range   = res_data.in_range;
   assign rsp_chan.temp_code  = res_data.temp_code;
   assign rsp_chan.volt_code  = res_data.volt_code;

   // out-of-span samples carry the fill temperature and the lowest code
   `CSAT_NEVER(a_out_of_span_fill, clock, reset, rsp_chan.valid && !rsp_chan.in_range && (rsp_chan.temp_centi != OutCenti || rsp_chan.temp_code != '0))
   // interpolated temperature stays inside the table span
   `CSAT_ASSERT(a_centi_span, clock, reset, rsp_chan.valid && rsp_chan.in_range |-> rsp_chan.temp_centi >= MinCenti && rsp_chan.temp_centi <= MaxCenti)
   // code saturates low below -20 C
   `CSAT_ASSERT(a_code_cold, clock, reset, rsp_chan.valid && rsp_chan.in_range && rsp_chan.temp_centi < ColdCenti |-> rsp_chan.temp_code == '0)
   // code saturates high above 107.5 C
   `CSAT_ASSERT(a_code_hot, clock, reset, rsp_chan.valid && rsp_chan.in_range && rsp_chan.temp_centi > HotCenti |-> rsp_chan.temp_code == TcodeMax)

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// self-checking testbench of the cell sample to temperature and code converter
`timescale 1ns / 1ps
module tb_top;
   import csat_pkg::*;

   // one expected reading together with the sample it came from
   typedef struct {
      logic [CodeW-1:0] code;
      result_type       res;
   } reading_type;

   localparam int CycleLimit = 300000;
   localparam int DrainCycles = 16;
   localparam int RandomSamples = 600;

   logic clock = 1'b0;
   logic reset;

   csat_req_if req_chan ();
   csat_rsp_if rsp_chan ();

   cell_sample_to_temp_and_codes_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   logic [CodeW-1:0] sample_queue [$];
   reading_type      expected_readings [$];

   logic        req_fire = 1'b0;
   logic        calm = 1'b0;
   int unsigned send_gap = 0;
   int unsigned recv_gap = 0;
   int unsigned cycle_count = 0;
   int unsigned fail_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned readings_checked = 0;
   int unsigned in_range_count = 0;
   int unsigned tcode_clamped = 0;
   int unsigned vcode_clamped = 0;
   result_type  got;
   reading_type want;

   // clock
   always #4 clock = ~clock;

   // interpolate the thermistor table and build both codes
   function automatic result_type convert_sample(input logic [CodeW-1:0] code);
      int v;
      int d;
      int n;
      int centi;
      int t2;
      int q;
      int c;
      int base_c;
      bit found;
      result_type r;
      v = int'(code);
      centi = -10000;
      found = 1'b0;
      r.temp_code = '0;
      for (int i = 0; i < NumSegs; i++) begin
         if (!found && v <= int'(PointVolt[i]) && v >= int'(PointVolt[i+1])) begin
            found = 1'b1;
            base_c = -40 + 5 * i;
            d = int'(PointVolt[i]) - int'(PointVolt[i+1]);
            n = int'(PointVolt[i]) - v;
            centi = base_c * 100 + (n * 1000 + d) / (2 * d);
            // code from the exact temperature, not from the rounded one
            t2 = 4 * d * (base_c + 20) + 20 * n + d;
            if (t2 < 0) begin
               r.temp_code = '0;
            end else begin
               q = t2 / (2 * d);
               r.temp_code = (q > 255) ? TcodeMax : TcodeW'(q);
            end
         end
      end
      r.temp_centi = CentiW'(centi);
      r.in_range = found;
      // voltage code with clamping to 2.00 .. 4.55 V
      c = v;
      if (c < 20000) c = 20000;
      if (c > 45500) c = 45500;
      r.volt_code = VcodeW'((c - 20000 + 50) / 100);
      return r;
   endfunction

   // gap length: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // random sample: weighted toward the table span, its breakpoints and the voltage clamp edges
   function automatic logic [CodeW-1:0] random_sample();
      int unsigned r;
      int v;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         v = $urandom_range(13000, 24400);
      end else if (r < 65) begin
         v = int'(PointVolt[$urandom_range(0, NumPts - 1)]) + int'($urandom_range(0, 6)) - 3;
      end else if (r < 75) begin
         v = $urandom_range(19900, 20100);
      end else if (r < 82) begin
         v = $urandom_range(45400, 45600);
      end else begin
         v = $urandom_range(0, 65535);
      end
      return CodeW'(v);
   endfunction

   // cycle counter and watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d readings outstanding",
                  cycle_count, expected_readings.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // calm stretches with no idling on either side
   always @(negedge clock) begin
      if (cycle_count % 64 == 0) begin
         calm <= ($urandom_range(0, 3) == 0);
      end
   end

   // sample driver
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_fire) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_chan.valid <= 1'b0;
         end else if (sample_queue.size() > 0) begin
            req_chan.valid <= 1'b1;
            req_chan.cell_code <= sample_queue.pop_front();
            send_gap <= calm ? 0 : pick_gap();
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (!calm && $urandom_range(0, 3) == 0) begin
            recv_gap <= pick_gap();
         end
      end
   end

   // monitor: check response beats, then record accepted sample beats
   always @(posedge clock) begin
      req_fire <= !reset && req_chan.valid && req_chan.ready;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.temp_centi = rsp_chan.temp_centi;
            got.in_range = rsp_chan.in_range;
            got.temp_code = rsp_chan.temp_code;
            got.volt_code = rsp_chan.volt_code;
            if (expected_readings.size() == 0) begin
               fail_count++;
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected reading: temp %0d in_range %0b tcode %0d vcode %0d",
                           got.temp_centi, got.in_range, got.temp_code, got.volt_code);
               end
            end else begin
               want = expected_readings.pop_front();
               readings_checked++;
               if (want.res.in_range) in_range_count++;
               if (want.res.in_range && (want.res.temp_code == 0 ||
                                         want.res.temp_code == TcodeMax)) tcode_clamped++;
               if (want.res.volt_code == 0 || want.res.volt_code == 8'd255) vcode_clamped++;
               if (got.temp_centi != want.res.temp_centi ||
                   got.in_range != want.res.in_range ||
                   got.temp_code != want.res.temp_code ||
                   got.volt_code != want.res.volt_code) begin
                  fail_count++;
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("sample %0d: expected temp %0d in_range %0b tcode %0d vcode %0d, got temp %0d in_range %0b tcode %0d vcode %0d",
                              want.code, want.res.temp_centi, want.res.in_range,
                              want.res.temp_code, want.res.volt_code, got.temp_centi,
                              got.in_range, got.temp_code, got.volt_code);
                  end
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            want.code = req_chan.cell_code;
            want.res = convert_sample(req_chan.cell_code);
            expected_readings.push_back(want);
         end
      end
   end

   // stimulus, reset and end of run
   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.cell_code = '0;
      rsp_chan.ready = 1'b0;

      // directed: field extremes, table ends, points, midpoints, clamp edges
      sample_queue = '{16'd0, 16'd65535, 16'd12999, 16'd13000, 16'd24400, 16'd24401,
                       16'd23500, 16'd23501, 16'd23499, 16'd24300, 16'd24299,
                       16'd21400, 16'd13250, 16'd13251, 16'd13249, 16'd13100,
                       16'd19949, 16'd19950, 16'd20049, 16'd20050, 16'd45449,
                       16'd45450, 16'd45500, 16'd45501, 16'd32768};
      for (int i = 0; i < RandomSamples; i++) begin
         sample_queue.push_back(random_sample());
      end

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // all samples accepted, all readings back, then a short drain
      do @(posedge clock); while (sample_queue.size() > 0 || req_chan.valid);
      do @(posedge clock); while (expected_readings.size() > 0);
      repeat (DrainCycles) @(posedge clock);

      $display("checked %0d readings in %0d cycles, %0d inside the table span",
               readings_checked, cycle_count, in_range_count);
      $display("clamped codes seen: %0d temperature, %0d voltage; %0d mismatches",
               tcode_clamped, vcode_clamped, mismatch_count);
      if (fail_count == 0 && expected_readings.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
